FILE: rtl/ils_pkg.sv
// Package for the indexed list store: sizes, command and status codes,
// and the structs passed between the sequencer, the entry memory and the top level.
// No dependencies.
package ils_pkg;

    localparam int CAPACITY = 256;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int CMD_W = 3;
    localparam int POS_W = 9;
    localparam int VAL_W = 32;
    localparam int ST_W  = 2;
    localparam int LEN_W = 9;

    // Width in which positions and the entry count are compared.
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam int IN_W        = CMD_W + POS_W + VAL_W;
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W       = VAL_W + ST_W + LEN_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    localparam logic [CMD_W-1:0] CMD_READ   = CMD_W'(0);
    localparam logic [CMD_W-1:0] CMD_FRONT  = CMD_W'(1);
    localparam logic [CMD_W-1:0] CMD_APPEND = CMD_W'(2);
    localparam logic [CMD_W-1:0] CMD_INSERT = CMD_W'(3);
    localparam logic [CMD_W-1:0] CMD_DELETE = CMD_W'(4);

    localparam logic [ST_W-1:0] ST_DONE  = ST_W'(0);
    localparam logic [ST_W-1:0] ST_RANGE = ST_W'(1);
    localparam logic [ST_W-1:0] ST_FULL  = ST_W'(2);

    typedef struct packed {
        logic              re;
        logic [ADDR_W-1:0] raddr;
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [VAL_W-1:0]  wdata;
    } mem_req_t;

    typedef struct packed {
        logic [VAL_W-1:0] read_value;
        logic [ST_W-1:0]  status;
        logic [LEN_W-1:0] list_length;
    } result_t;

endpackage

FILE: rtl/indexed_list_store.sv
// Top level of the indexed list store: stream ports, the output register,
// and the sequencer and entry memory. Depends on ils_pkg, ils_store and ils_seq.
//
// The block keeps an ordered list of up to CAPACITY signed 32-bit entries.
// Each transfer on the s_ channel carries one command: read at a position,
// insert at the front, append, insert before a position, or delete at a
// position. Every command answers with exactly one transfer on the m_
// channel carrying the read value, a status code and the new list length.
//
// Commands are handled one at a time. A read in range waits for the registered
// read data of the memory; a rejected command, a read past the end and an unused
// code go straight to the result. An insert shifts the entries from p on back
// one slot, tail first, then writes the new entry; a delete shifts the entries
// after p forward one slot. The memory moves one slot per cycle through its
// single read and write ports; s_tready returns as the result is loaded.
//
// The result sits in an output register, so a finished command waits there
// while the receiver stalls and the next command is already taken. A command
// that finishes while that register is still full waits until it drains.
// Reset empties the list; stored entries are not cleared.
module indexed_list_store (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // Fields from bit 0 up: cmd[2:0], position[11:3], item_value[43:12], zero fill.
    input  logic [ils_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // Fields from bit 0 up: read_value[31:0], status[33:32], list_length[42:34], zero fill.
    output logic [ils_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import ils_pkg::*;

    mem_req_t         mem_req;
    logic [VAL_W-1:0] mem_rdata;
    result_t          result;
    logic             done;
    logic             out_free;

    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] item_value;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // Unpack the command fields, lowest field first.
    assign cmd        = s_tdata[CMD_W-1:0];
    assign position   = s_tdata[CMD_W+POS_W-1:CMD_W];
    assign item_value = s_tdata[IN_W-1:CMD_W+POS_W];

    ils_store u_store (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    ils_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .cmd        (cmd),
        .position   (position),
        .item_value (item_value),
        .mem_req    (mem_req),
        .mem_rdata  (mem_rdata),
        .out_free   (out_free),
        .done       (done),
        .result     (result)
    );

    // The output register may be reloaded in the same cycle it is drained.
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (done)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = OUT_TDATA_W'({result.list_length, result.status,
                                          result.read_value});
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // A result is only produced while the sequencer is busy with a command.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !s_tready)
        else $error("result produced while accepting commands");

    // A full-list rejection always reports the full length.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[VAL_W+ST_W-1:VAL_W] == ST_FULL)
        |-> m_tdata[OUT_W-1:VAL_W+ST_W] == LEN_W'(CAPACITY))
        else $error("full status with a list that is not full");

    // A stalled result is never dropped.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("stalled result lost");

endmodule

FILE: rtl/ils_store.sv
// Entry memory of the indexed list store: one write port, one read port
// with registered read data. Depends on ils_pkg.
module ils_store (
    input  logic                     clk,
    input  ils_pkg::mem_req_t        req,
    output logic [ils_pkg::VAL_W-1:0] rdata
);
    import ils_pkg::*;

    logic [VAL_W-1:0] mem [CAPACITY];
    logic [VAL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/ils_seq.sv
// Command sequencer of the indexed list store: decodes a command, walks the
// entry memory one slot per cycle to open or close a gap, and keeps the count.
// Depends on ils_pkg.
module ils_seq (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [ils_pkg::CMD_W-1:0] cmd,
    input  logic [ils_pkg::POS_W-1:0] position,
    input  logic [ils_pkg::VAL_W-1:0] item_value,
    output ils_pkg::mem_req_t         mem_req,
    input  logic [ils_pkg::VAL_W-1:0] mem_rdata,
    input  logic                      out_free,
    output logic                      done,
    output ils_pkg::result_t          result
);
    import ils_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SHIFT  = 3'd1;
    localparam logic [2:0] S_DRAIN  = 3'd2;
    localparam logic [2:0] S_PUT    = 3'd3;
    localparam logic [2:0] S_RDWAIT = 3'd4;
    localparam logic [2:0] S_FIN    = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              pend_reg, pend_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [ADDR_W-1:0] end_reg, end_next;
    logic [ADDR_W-1:0] wa_reg, wa_next;
    logic [ADDR_W-1:0] at_reg, at_next;
    logic [VAL_W-1:0]  val_reg, val_next;
    logic [VAL_W-1:0]  rd_reg, rd_next;
    logic [ST_W-1:0]   st_reg, st_next;
    logic              del_reg, del_next;

    logic [CMP_W-1:0]  pos_c, cnt_c, at_c, cnt_full;
    logic              accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign pos_c    = CMP_W'(position);
    assign cnt_c    = CMP_W'(count_reg);
    assign cnt_full = CMP_W'(CAPACITY);

    always_comb
    begin
        case (cmd)
            CMD_FRONT:  at_c = '0;
            CMD_APPEND: at_c = cnt_c;
            default:    at_c = pos_c;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        pend_next  = 1'b0;
        idx_next   = idx_reg;
        end_next   = end_reg;
        wa_next    = wa_reg;
        at_next    = at_reg;
        val_next   = val_reg;
        rd_next    = rd_reg;
        st_next    = st_reg;
        del_next   = del_reg;
        done       = 1'b0;

        // A slot read in the previous cycle is written to its new place now.
        mem_req.re    = 1'b0;
        mem_req.raddr = idx_reg;
        mem_req.we    = pend_reg;
        mem_req.waddr = wa_reg;
        mem_req.wdata = mem_rdata;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rd_next    = '0;
                    st_next    = ST_DONE;
                    state_next = S_FIN;
                    case (cmd)
                        CMD_READ:
                        begin
                            if (pos_c < cnt_c)
                            begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = pos_c[ADDR_W-1:0];
                                state_next    = S_RDWAIT;
                            end
                            else
                            begin
                                rd_next = {VAL_W{1'b1}};
                                st_next = ST_RANGE;
                            end
                        end
                        CMD_FRONT, CMD_APPEND, CMD_INSERT:
                        begin
                            if (at_c > cnt_c)
                            begin
                                st_next = ST_RANGE;
                            end
                            else if (cnt_c >= cnt_full)
                            begin
                                st_next = ST_FULL;
                            end
                            else
                            begin
                                val_next = item_value;
                                at_next  = at_c[ADDR_W-1:0];
                                del_next = 1'b0;
                                if (at_c == cnt_c)
                                begin
                                    state_next = S_PUT;
                                end
                                else
                                begin
                                    // Move entries back one slot, starting from the tail.
                                    idx_next   = ADDR_W'(count_reg - CNT_W'(1));
                                    end_next   = at_c[ADDR_W-1:0];
                                    state_next = S_SHIFT;
                                end
                            end
                        end
                        CMD_DELETE:
                        begin
                            if (pos_c < cnt_c)
                            begin
                                del_next = 1'b1;
                                if (pos_c + CMP_W'(1) < cnt_c)
                                begin
                                    // Move entries forward one slot, starting after the hole.
                                    idx_next   = ADDR_W'(pos_c + CMP_W'(1));
                                    end_next   = ADDR_W'(count_reg - CNT_W'(1));
                                    state_next = S_SHIFT;
                                end
                                else
                                begin
                                    count_next = count_reg - CNT_W'(1);
                                end
                            end
                            else
                            begin
                                st_next = ST_RANGE;
                            end
                        end
                        default:
                        begin
                            st_next = ST_DONE;
                        end
                    endcase
                end
            end
            S_SHIFT:
            begin
                mem_req.re = 1'b1;
                pend_next  = 1'b1;
                wa_next    = del_reg ? idx_reg - ADDR_W'(1) : idx_reg + ADDR_W'(1);
                if (idx_reg == end_reg)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    idx_next = del_reg ? idx_reg + ADDR_W'(1) : idx_reg - ADDR_W'(1);
                end
            end
            S_DRAIN:
            begin
                if (del_reg)
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_PUT;
                end
            end
            S_PUT:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = at_reg;
                mem_req.wdata = val_reg;
                count_next    = count_reg + CNT_W'(1);
                state_next    = S_FIN;
            end
            S_RDWAIT:
            begin
                rd_next    = mem_rdata;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        end_reg <= end_next;
        wa_reg  <= wa_next;
        at_reg  <= at_next;
        val_reg <= val_next;
        rd_reg  <= rd_next;
        st_reg  <= st_next;
        del_reg <= del_next;
    end

    assign result.read_value  = rd_reg;
    assign result.status      = st_reg;
    assign result.list_length = cnt_c[LEN_W-1:0];

endmodule
